/* rtl/salkv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salkv_pkg
// shared types and constants of the set-associative lru key-value cache
// ----------------------------------------------------------------------------
package salkv_pkg;

	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 32;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef enum logic [8:0] {
		ST_CLR   = 9'b000000001,
		ST_IDLE  = 9'b000000010,
		ST_MOD   = 9'b000000100,
		ST_LOAD  = 9'b000001000,
		ST_WALK  = 9'b000010000,
		ST_DEC   = 9'b000100000,
		ST_FRONT = 9'b001000000,
		ST_WB    = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

endpackage

/* rtl/set_assoc_lru_key_value_cache.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_key_value_cache
// key-value cache of SETS sets by WAYS ways with lru replacement
// ----------------------------------------------------------------------------
// One item at a time: a read (tuser 0) or a write (tuser 1) of a 32-bit key
// and value. Each set is one row of a single-port-style memory holding all
// its ways' keys, values and prev/next links plus the list head and the
// count of ways handed out. After the accepting cycle an item goes through
// the key modulo SETS, a memory read, a load, a list walk in the loaded
// row, a decision, a move-to-front, a write back and the load of the
// output register, which waits until the output is free. A read miss skips
// move-to-front and write back, and a negative key goes straight to the
// output step. A result waiting at the output does not block acceptance of
// the next item, but that item's result waits until the output is taken.
// After reset a clearing pass writes the empty row into every set; no item
// is taken during it. Negative keys give hit 0 and value 0 and change
// nothing. A write returns hit 1 when the key was already present.
// ----------------------------------------------------------------------------
module set_assoc_lru_key_value_cache #(
	parameter int SETS = 16,
	parameter int WAYS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // [31:0] lookup_key, [63:32] write_value
	input  logic [0:0]  s_tuser,  // [0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [31:0] read_value
	output logic [0:0]  m_tuser   // [0] hit
);

	localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int IW = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int CW = $clog2(WAYS + 1);

	// a link is a way index with a valid mark; invalid means none
	typedef struct packed {
		logic          vld;
		logic [IW-1:0] idx;
	} link_t;

	// one memory row holds a whole set
	typedef struct packed {
		logic [WAYS-1:0][30:0] key;
		logic [WAYS-1:0][31:0] val;
		link_t [WAYS-1:0]      prv;
		link_t [WAYS-1:0]      nxt;
		link_t                 head;
		logic [CW-1:0]         cnt;
	} row_t;

	salkv_pkg::state_t state_q;

	row_t mem [SETS];
	row_t rd_q;
	row_t row_q;
	row_t init_row;

	logic [SW-1:0] clr_q;
	logic [SW-1:0] set_q;
	logic          op_q;
	logic [30:0]   key_q;
	logic [31:0]   val_q;

	link_t         pos_q, tail_q;
	logic [CW-1:0] steps_q;
	logic          found_q;
	logic [IW-1:0] tp_q;
	logic          res_hit_q;
	logic [31:0]   res_val_q;

	logic          out_valid_q;
	logic          out_hit_q;
	logic [31:0]   out_val_q;

	logic          accept;
	logic          mod_in;
	logic          mod_valid;
	logic [SW-1:0] mod_set;
	logic          mem_we, mem_re;
	logic [SW-1:0] mem_wa;
	row_t          mem_wd;

	// walk step and write-target decision
	logic          walk_more;
	logic          cnt_full;
	logic [CW:0]   cnt_inc;
	logic [IW-1:0] tp_c;
	logic          dec_front;
	logic          out_free;
	link_t         head_c, p_c, n_c;

	assign accept   = s_tvalid & s_tready;
	assign s_tready = (state_q == salkv_pkg::ST_IDLE);
	assign mod_in   = accept & ~s_tdata[31];
	assign out_free = ~out_valid_q | m_tready;

	salkv_set_index #(
		.SETS(SETS),
		.SW  (SW)
	) u_set_index (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (mod_in),
		.key      (s_tdata[30:0]),
		.out_valid(mod_valid),
		.set_idx  (mod_set)
	);

	// empty set: no head, nothing handed out, spare ways chained in order
	always_comb begin
		init_row = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (w > 0)
				init_row.prv[w] = link_t'{vld: 1'b1, idx: IW'(w - 1)};
			if (w + 1 < WAYS)
				init_row.nxt[w] = link_t'{vld: 1'b1, idx: IW'(w + 1)};
		end
	end

	assign mem_we = (state_q == salkv_pkg::ST_CLR) | (state_q == salkv_pkg::ST_WB);
	assign mem_wa = (state_q == salkv_pkg::ST_CLR) ? clr_q : set_q;
	assign mem_wd = (state_q == salkv_pkg::ST_CLR) ? init_row : row_q;
	assign mem_re = (state_q == salkv_pkg::ST_MOD) & mod_valid;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (mem_re)
			rd_q <= mem[mod_set];
	end

	// walk continues while the way is live and its key differs
	assign walk_more = pos_q.vld && (steps_q < CW'(WAYS)) && (row_q.key[pos_q.idx] != key_q);

	assign cnt_full = (row_q.cnt >= CW'(WAYS));
	assign cnt_inc  = {1'b0, row_q.cnt} + (CW+1)'(1);

	always_comb begin
		if (found_q)
			tp_c = pos_q.idx;
		else if (cnt_full)
			tp_c = tail_q.idx;
		else
			tp_c = row_q.cnt[IW-1:0];
	end

	// a read miss, or a full set with no tail, ends without touching the row
	always_comb begin
		if (op_q == salkv_pkg::OP_READ)
			dec_front = found_q;
		else
			dec_front = found_q | ~cnt_full | tail_q.vld;
	end

	assign head_c = row_q.head;
	assign p_c    = row_q.prv[tp_q];
	assign n_c    = row_q.nxt[tp_q];

	// working copy of the set
	always_ff @(posedge clk) begin
		case (state_q)
			salkv_pkg::ST_LOAD: begin
				row_q <= rd_q;
			end
			salkv_pkg::ST_DEC: begin
				if (dec_front && op_q == salkv_pkg::OP_WRITE) begin
					if (!found_q && !cnt_full) begin
						row_q.cnt <= cnt_inc[CW-1:0];
						row_q.nxt[tp_c] <= '0;
						if (cnt_inc < (CW+1)'(WAYS))
							row_q.prv[cnt_inc[IW-1:0]] <= '0;
					end
					row_q.key[tp_c] <= key_q;
					row_q.val[tp_c] <= val_q;
				end
			end
			salkv_pkg::ST_FRONT: begin
				// unlink, then splice in at the head; later writes win
				if (!(head_c.vld && head_c.idx == tp_q)) begin
					if (p_c.vld)
						row_q.nxt[p_c.idx] <= n_c;
					if (n_c.vld)
						row_q.prv[n_c.idx] <= p_c;
					row_q.nxt[tp_q] <= head_c;
					row_q.prv[tp_q] <= '0;
					if (head_c.vld)
						row_q.prv[head_c.idx] <= link_t'{vld: 1'b1, idx: tp_q};
					row_q.head <= link_t'{vld: 1'b1, idx: tp_q};
				end
			end
			default: begin
			end
		endcase
	end

	// item payload, walk registers and result
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= s_tuser[0];
			key_q     <= s_tdata[30:0];
			val_q     <= s_tdata[63:32];
			res_hit_q <= 1'b0;
			res_val_q <= '0;
		end
		if (mem_re)
			set_q <= mod_set;
		case (state_q)
			salkv_pkg::ST_LOAD: begin
				pos_q   <= rd_q.head;
				tail_q  <= rd_q.head;
				steps_q <= '0;
			end
			salkv_pkg::ST_WALK: begin
				if (walk_more) begin
					tail_q  <= pos_q;
					pos_q   <= row_q.nxt[pos_q.idx];
					steps_q <= steps_q + CW'(1);
				end else begin
					found_q <= pos_q.vld && (steps_q < CW'(WAYS));
				end
			end
			salkv_pkg::ST_DEC: begin
				tp_q      <= tp_c;
				res_hit_q <= found_q;
				if (op_q == salkv_pkg::OP_READ && found_q)
					res_val_q <= row_q.val[pos_q.idx];
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= salkv_pkg::ST_CLR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				salkv_pkg::ST_CLR: begin
					clr_q <= clr_q + SW'(1);
					if (clr_q == SW'(SETS - 1))
						state_q <= salkv_pkg::ST_IDLE;
				end
				salkv_pkg::ST_IDLE: begin
					if (accept)
						state_q <= s_tdata[31] ? salkv_pkg::ST_DONE : salkv_pkg::ST_MOD;
				end
				salkv_pkg::ST_MOD: begin
					if (mod_valid)
						state_q <= salkv_pkg::ST_LOAD;
				end
				salkv_pkg::ST_LOAD: begin
					state_q <= salkv_pkg::ST_WALK;
				end
				salkv_pkg::ST_WALK: begin
					if (!walk_more)
						state_q <= salkv_pkg::ST_DEC;
				end
				salkv_pkg::ST_DEC: begin
					state_q <= dec_front ? salkv_pkg::ST_FRONT : salkv_pkg::ST_DONE;
				end
				salkv_pkg::ST_FRONT: begin
					state_q <= salkv_pkg::ST_WB;
				end
				salkv_pkg::ST_WB: begin
					state_q <= salkv_pkg::ST_DONE;
				end
				salkv_pkg::ST_DONE: begin
					if (out_free)
						state_q <= salkv_pkg::ST_IDLE;
				end
				default: begin
					state_q <= salkv_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == salkv_pkg::ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == salkv_pkg::ST_DONE && out_free) begin
			out_hit_q <= res_hit_q;
			out_val_q <= res_val_q;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_val_q;
	assign m_tuser[0] = out_hit_q;

endmodule

/* rtl/salkv_set_index.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salkv_set_index
// two-stage key modulo SETS by reciprocal multiply and one correction
// ----------------------------------------------------------------------------
module salkv_set_index #(
	parameter int SETS = 16,
	parameter int SW   = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [30:0]   key,
	output logic          out_valid,
	output logic [SW-1:0] set_idx
);

	localparam logic [32:0] RECIP = 33'((64'd1 << 32) / SETS);

	logic          v_s1, v_s2;
	logic [30:0]   key_s1;
	logic [31:0]   q_s1;
	logic [SW:0]   r_s2;
	logic [63:0]   prod;
	logic [31:0]   qs;
	logic [31:0]   diff;

	assign prod = {33'b0, key} * {31'b0, RECIP};
	assign qs   = q_s1 * 32'(SETS);
	assign diff = {1'b0, key_s1} - qs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		key_s1 <= key;
		q_s1   <= prod[63:32];
		r_s2   <= diff[SW:0];
	end

	// estimate is low by at most one, so the remainder is below 2*SETS
	always_comb begin
		if (r_s2 >= (SW+1)'(SETS))
			set_idx = SW'(r_s2 - (SW+1)'(SETS));
		else
			set_idx = r_s2[SW-1:0];
	end

	assign out_valid = v_s2;

endmodule
